/* sv/tss_pkg.sv */
package tss_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TAG_W  = 4;
    localparam int VAL_W  = 16;
    localparam int FUNC_W = 3;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FN_PUSH     = 3'd0;
    localparam func_t FN_POP      = 3'd1;
    localparam func_t FN_RETRIEVE = 3'd2;
    localparam func_t FN_DELETE   = 3'd3;
    localparam func_t FN_UPDATE   = 3'd4;
    localparam func_t FN_PEEK     = 3'd5;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_MISS
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_TOP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [TAG_W-1:0]  wtag;
        logic [VAL_W-1:0]  wval;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_ctl_t;

endpackage

/* sv/tss_store.sv */
module tss_store
    import tss_pkg::*;
(
    input  logic             clk,
    input  mem_ctl_t         ctl,
    output logic [TAG_W-1:0] rd_tag,
    output logic [VAL_W-1:0] rd_val
);

    logic [TAG_W+VAL_W-1:0] mem [DEPTH];
    logic [TAG_W+VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= {ctl.wtag, ctl.wval};
        end
        if (ctl.re)
        begin
            rd_data_reg <= mem[ctl.raddr];
        end
    end

    assign rd_tag = rd_data_reg[TAG_W+VAL_W-1:VAL_W];
    assign rd_val = rd_data_reg[VAL_W-1:0];

endmodule

/* sv/tagged_stack_with_search.sv */
// Tagged LIFO stack with search by tag.
//
// Command channel: func, tag and item_value are taken at a rising edge with
// start high and busy low. busy stays high until the result has been shown.
// Result channel: done is high for exactly one cycle and qualifies status,
// found_value, top_valid, top_tag, top_value and depth in that cycle. The
// receiver has no way to stall; the result is gone after that cycle.
//
// Sequence after the accepting edge: retrieve, update and delete on a
// non-empty stack scan entries from the top down in S_SCAN; a delete that
// hits below the top then moves each entry above the match down one place
// in S_SHIFT; every command then passes S_TOP, which reads the new top
// entry, and S_DONE. Worst case: delete of the bottom entry, full stack.
// The entries live in a single-port-write, registered-read array; one tag
// comparator is reused each cycle while the sequencer walks the array, so
// the scan and the gap-closing shift run one entry per cycle.
// Next command may be issued the cycle after done.
// Reset empties the stack (depth zero); entry contents are not cleared.
module tagged_stack_with_search
    import tss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [TAG_W-1:0]  tag,
    input  logic [VAL_W-1:0]  item_value,
    output logic              done,
    output logic [1:0]        status,
    output logic [VAL_W-1:0]  found_value,
    output logic              top_valid,
    output logic [TAG_W-1:0]  top_tag,
    output logic [VAL_W-1:0]  top_value,
    output logic [CNT_W-1:0]  depth
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    func_t              op_reg, op_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    status_t            status_reg, status_next;
    logic [VAL_W-1:0]   found_reg, found_next;

    mem_ctl_t           mem_ctl;
    logic [TAG_W-1:0]   rd_tag;
    logic [VAL_W-1:0]   rd_val;

    logic               is_search;
    logic               hit;
    logic               at_bottom;
    logic               at_top;
    logic               shift_last;
    logic [CNT_W-1:0]   idx_wide;
    logic [ADDR_W-1:0]  top_addr;

    tss_store u_store (
        .clk    (clk),
        .ctl    (mem_ctl),
        .rd_tag (rd_tag),
        .rd_val (rd_val)
    );

    assign is_search  = (func == FN_RETRIEVE) || (func == FN_DELETE) || (func == FN_UPDATE);
    assign hit        = (rd_tag == tag_reg);
    assign idx_wide   = CNT_W'(idx_reg);
    assign at_bottom  = (idx_reg == '0);
    assign at_top     = ((idx_wide + CNT_W'(1)) == cnt_reg);
    assign shift_last = ((idx_wide + CNT_W'(2)) == cnt_reg);
    assign top_addr   = ADDR_W'(cnt_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        tag_reg    <= tag_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (is_search && (cnt_reg != '0)) ? S_SCAN : S_TOP;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = ((op_reg == FN_DELETE) && !at_top) ? S_SHIFT : S_TOP;
                end
                else if (at_bottom)
                begin
                    state_next = S_TOP;
                end
            end
            S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:  state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and array control
    always_comb
    begin
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        tag_next    = tag_reg;
        val_next    = val_reg;
        status_next = status_reg;
        found_next  = found_reg;
        mem_ctl     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = func;
                    tag_next    = tag;
                    val_next    = item_value;
                    status_next = ST_OK;
                    found_next  = '0;
                    priority if (func == FN_PUSH)
                    begin
                        if (cnt_reg == CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_ctl.we    = 1'b1;
                            mem_ctl.waddr = ADDR_W'(cnt_reg);
                            mem_ctl.wtag  = tag;
                            mem_ctl.wval  = item_value;
                            cnt_next      = cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (func == FN_POP)
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                    end
                    else if (is_search)
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_MISS;
                        end
                        else
                        begin
                            idx_next      = top_addr;
                            mem_ctl.re    = 1'b1;
                            mem_ctl.raddr = top_addr;
                        end
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    priority if (op_reg == FN_RETRIEVE)
                    begin
                        found_next = rd_val;
                    end
                    else if (op_reg == FN_UPDATE)
                    begin
                        mem_ctl.we    = 1'b1;
                        mem_ctl.waddr = idx_reg;
                        mem_ctl.wtag  = rd_tag;
                        mem_ctl.wval  = val_reg;
                    end
                    else if (at_top)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        mem_ctl.re    = 1'b1;
                        mem_ctl.raddr = idx_reg + ADDR_W'(1);
                    end
                end
                else if (at_bottom)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    idx_next      = idx_reg - ADDR_W'(1);
                    mem_ctl.re    = 1'b1;
                    mem_ctl.raddr = idx_reg - ADDR_W'(1);
                end
            end
            S_SHIFT:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = idx_reg;
                mem_ctl.wtag  = rd_tag;
                mem_ctl.wval  = rd_val;
                idx_next      = idx_reg + ADDR_W'(1);
                if (shift_last)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    mem_ctl.re    = 1'b1;
                    mem_ctl.raddr = idx_reg + ADDR_W'(2);
                end
            end
            S_TOP:
            begin
                mem_ctl.re    = 1'b1;
                mem_ctl.raddr = top_addr;
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        done        = (state_reg == S_DONE);
        status      = status_reg;
        found_value = found_reg;
        depth       = cnt_reg;
        top_valid   = (cnt_reg != '0);
        top_tag     = top_valid ? rd_tag : '0;
        top_value   = top_valid ? rd_val : '0;
    end

endmodule
